// ===== sv/lphash_pkg.sv =====
// ----------------------------------------------------------------------------
// lphash_pkg
// Shared types and codes for the linear probing hash table.
// ----------------------------------------------------------------------------
package lphash_pkg;

  localparam int MIN_LOG2 = 3;
  localparam int MAX_LOG2 = 6;
  localparam int COUNT_W  = 7;

  localparam logic [2:0] CFG_RESET = 3'd6;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_FOUND   = 3'd2;
  localparam logic [2:0] ST_MISS    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [63:0] key_hash;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [63:0]        found_value;
    logic [COUNT_W-1:0] entry_count_out;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic resolved;
  } stat_t;

endpackage

// ===== sv/linear_probe_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing hash table with linear probing, 64-bit keys and values.
// ----------------------------------------------------------------------------
// Channels: req (cmd, key, key_hash, value) and rsp (status, found_value,
// entry_count_out), both valid/ready; cfg writes slots_log2, always ready.
// The user must write it only while no transaction is in flight (unenforced).
// Each request gives exactly one response. One request is in flight at a
// time. The probe loop visits each slot in turn with a memory read, then a
// compare and decide step, until the request resolves.
// A completed result sits in the output register; if it has not been taken
// when the next result is ready, the probe loop holds until it is.
// Reset clears every slot's valid bit and the entry count and sets
// slots_log2 to 6; the table is ready as soon as reset is released.
// Capacity in use is 2^slots_log2, clamped to 8 and to the slots built.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top
  import lphash_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  localparam int FLOOR_LOG2 = $clog2(SLOTS + 1) - 1;
  localparam int DEPTH_LOG2 = (FLOOR_LOG2 > MAX_LOG2) ? MAX_LOG2 : FLOOR_LOG2;
  localparam int DEPTH      = 1 << DEPTH_LOG2;

  ctl_t  ctl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  lphash_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  lphash_dp #(
    .DEPTH_LOG2 (DEPTH_LOG2)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .req      (req),
    .ctl      (ctl),
    .stat     (stat),
    .rsp      (rsp)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while another is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.entry_count_out <= COUNT_W'(DEPTH)))
    else $error("entry count exceeds slots built");

  a_value_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_FOUND)) |-> (rsp.found_value == '0))
    else $error("found_value set without a lookup hit");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status <= ST_FULL))
    else $error("undefined status code");

endmodule

// ===== sv/lphash_ctrl.sv =====
// ----------------------------------------------------------------------------
// lphash_ctrl
// Sequencer: accepts a transaction, steps the probe loop, hands the result
// to the output register.
// ----------------------------------------------------------------------------
module lphash_ctrl
  import lphash_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  input  stat_t stat,
  output ctl_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_CHECK = 3'b100
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  always_comb begin
    ctl            = '0;
    state_next     = state;
    rsp_valid_next = rsp_valid && !rsp_ready;
    req_ready      = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.load   = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.resolved) begin
          ctl.advance = 1'b1;
          state_next  = S_FETCH;
        end else if (!rsp_valid || rsp_ready) begin
          ctl.commit     = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ===== sv/lphash_dp.sv =====
// ----------------------------------------------------------------------------
// lphash_dp
// Slot store, probe pointer, key compare, entry count and result register.
// ----------------------------------------------------------------------------
module lphash_dp
  import lphash_pkg::*;
#(
  parameter int DEPTH_LOG2 = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  input  req_t       req,
  input  ctl_t       ctl,
  output stat_t      stat,
  output rsp_t       rsp
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
  } entry_t;

  entry_t                slot_mem [DEPTH];
  entry_t                rd_q;
  logic [DEPTH-1:0]      slot_valid;
  req_t                  item;
  logic [DEPTH_LOG2-1:0] slot;
  logic [DEPTH_LOG2-1:0] probe_n;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;
  logic [2:0]            slots_log2;
  logic [2:0]            l_lo;
  logic [2:0]            l_eff;
  logic [DEPTH_LOG2:0]   cap;
  logic [DEPTH_LOG2-1:0] mask;
  logic                  is_ins;
  logic                  is_look;
  logic                  empty;
  logic                  match;
  logic                  last;
  logic [2:0]            status;
  logic [63:0]           found;

  always_comb begin
    l_lo  = (slots_log2 < 3'(MIN_LOG2)) ? 3'(MIN_LOG2) : slots_log2;
    l_eff = (l_lo > 3'(DEPTH_LOG2)) ? 3'(DEPTH_LOG2) : l_lo;
    cap   = (DEPTH_LOG2 + 1)'(1) << l_eff;
    mask  = DEPTH_LOG2'(cap - 1'b1);
  end

  always_comb begin
    is_ins  = (item.cmd == CMD_INSERT);
    is_look = (item.cmd == CMD_LOOKUP);
    empty   = !slot_valid[slot];
    match   = (rd_q.key == item.key);
    last    = (probe_n == mask);
    stat.resolved = !(is_ins || is_look) || empty || match || last;

    status     = ST_MISS;
    found      = '0;
    count_next = count;
    case (item.cmd)
      CMD_CLEAR: begin
        count_next = '0;
      end
      CMD_INSERT: begin
        if (empty) begin
          status     = ST_NEW;
          count_next = count + 1'b1;
        end else if (match) begin
          status = ST_UPDATED;
        end else begin
          status = ST_FULL;
        end
      end
      CMD_LOOKUP: begin
        if (!empty && match) begin
          status = ST_FOUND;
          found  = rd_q.value;
        end
      end
      default: begin
        status = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_log2 <= CFG_RESET;
    end else if (cfg_we) begin
      slots_log2 <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item    <= req;
      slot    <= req.key_hash[DEPTH_LOG2-1:0] & mask;
      probe_n <= '0;
    end else if (ctl.advance) begin
      slot    <= (slot + 1'b1) & mask;
      probe_n <= probe_n + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= slot_mem[slot];
    if (ctl.commit && is_ins && (empty || match)) begin
      slot_mem[slot] <= '{key: item.key, value: item.value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      count      <= '0;
    end else if (ctl.commit) begin
      count <= count_next;
      if (item.cmd == CMD_CLEAR) begin
        slot_valid <= '0;
      end else if (is_ins && empty) begin
        slot_valid[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp <= '{status: status, found_value: found, entry_count_out: count_next};
    end
  end

endmodule

// ===== dv/linear_probe_hash_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top_tb
// Self-checking bench for the linear probing hash table. A directed part
// covers empty lookups, extreme keys and hashes, wraparound, update, clear,
// the unused command, a full table and a capacity change while the table
// holds entries. Random traffic then draws keys from small pools with
// clustered home slots at each capacity, under three idle patterns. Every
// response is compared field by field against an in-bench probe model.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top_tb;
  import lphash_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         TBL_SLOTS  = 64;
  localparam int         POOL_MAX   = 96;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_ready;
  req_t       req_item;
  logic       rsp_valid;
  logic       rsp_ready;
  rsp_t       rsp_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_data;

  logic              tbl_valid [TBL_SLOTS];
  logic [63:0]       tbl_key   [TBL_SLOTS];
  logic [63:0]       tbl_value [TBL_SLOTS];
  logic [COUNT_W-1:0] tbl_count;
  logic [2:0]        cap_log2_reg;

  rsp_t        pending_rsp [$];
  logic [63:0] pool_key  [POOL_MAX];
  logic [63:0] pool_hash [POOL_MAX];

  int tx_idle_pct;
  int rx_idle_pct;
  int mismatch_count;
  int req_count;
  int rsp_count;
  int cfg_writes;
  int status_seen [5];

  linear_probe_hash_table_top #(
    .SLOTS(TBL_SLOTS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(40_000_000);
    $display("Timed out with %0d responses outstanding", pending_rsp.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int cap_log2_used();
    if (cap_log2_reg < MIN_LOG2) return MIN_LOG2;
    if (cap_log2_reg > MAX_LOG2) return MAX_LOG2;
    return int'(cap_log2_reg);
  endfunction

  function automatic void reset_table();
    for (int i = 0; i < TBL_SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_value[i] = '0;
    end
    tbl_count    = '0;
    cap_log2_reg = CFG_RESET;
  endfunction

  function automatic rsp_t probe_table(req_t r);
    rsp_t        res;
    int unsigned cap;
    int unsigned mask;
    int unsigned slot;
    int unsigned n;
    bit          done;
    res.status      = ST_MISS;
    res.found_value = '0;
    if (r.cmd == CMD_CLEAR) begin
      for (int i = 0; i < TBL_SLOTS; i++) tbl_valid[i] = 1'b0;
      tbl_count = '0;
    end else if (r.cmd == CMD_INSERT || r.cmd == CMD_LOOKUP) begin
      cap  = 1 << cap_log2_used();
      mask = cap - 1;
      slot = int'(r.key_hash[11:0]) & mask;
      res.status = (r.cmd == CMD_INSERT) ? ST_FULL : ST_MISS;
      done = 1'b0;
      for (n = 0; n < cap && !done; n++) begin
        if (!tbl_valid[slot]) begin
          if (r.cmd == CMD_INSERT) begin
            tbl_valid[slot] = 1'b1;
            tbl_key[slot]   = r.key;
            tbl_value[slot] = r.value;
            tbl_count       = tbl_count + 1'b1;
            res.status      = ST_NEW;
          end else begin
            res.status = ST_MISS;
          end
          done = 1'b1;
        end else if (tbl_key[slot] == r.key) begin
          if (r.cmd == CMD_INSERT) begin
            tbl_value[slot] = r.value;
            res.status      = ST_UPDATED;
          end else begin
            res.found_value = tbl_value[slot];
            res.status      = ST_FOUND;
          end
          done = 1'b1;
        end else begin
          slot = (slot + 1) & mask;
        end
      end
    end
    res.entry_count_out = tbl_count;
    return res;
  endfunction

  function automatic req_t mk_req(logic [1:0] cmd, logic [63:0] key, logic [63:0] key_hash,
                                  logic [63:0] value);
    req_t r;
    r.cmd      = cmd;
    r.key      = key;
    r.key_hash = key_hash;
    r.value    = value;
    return r;
  endfunction

  task automatic send_req(input req_t item);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_rsp.push_back(probe_table(item));
    req_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap_log2(input logic [2:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_log2_reg = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("Mismatch on %s at response %0d: expected %h, got %h",
               what, rsp_count, want, got);
  endtask

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        report_field("unexpected response", '0, 64'(rsp_item));
      end else begin
        want = pending_rsp.pop_front();
        if (want.status < 5) status_seen[want.status]++;
        if (rsp_item.status !== want.status)
          report_field("status", 64'(want.status), 64'(rsp_item.status));
        if (rsp_item.found_value !== want.found_value)
          report_field("found_value", want.found_value, rsp_item.found_value);
        if (rsp_item.entry_count_out !== want.entry_count_out)
          report_field("entry_count_out", 64'(want.entry_count_out),
                       64'(rsp_item.entry_count_out));
      end
      rsp_count++;
    end
  end

  task automatic test_directed_basics();
    send_req(mk_req(CMD_LOOKUP, 64'h1234, 64'h5, rand64()));
    send_req(mk_req(CMD_INSERT, '0, '0, '0));
    send_req(mk_req(CMD_INSERT, '1, '1, '1));
    send_req(mk_req(CMD_INSERT, 64'h2, 64'h3f, 64'hdead_beef_0000_0002));
    send_req(mk_req(CMD_LOOKUP, 64'h2, 64'h3f, rand64()));
    send_req(mk_req(CMD_INSERT, '0, '0, 64'h8000_0000_0000_0001));
    send_req(mk_req(CMD_LOOKUP, '0, '0, '1));
    send_req(mk_req(CMD_LOOKUP, '1, '1, '0));
    send_req(mk_req(CMD_LOOKUP, 64'h77, 64'hffff_ffff_ffff_ff3f, rand64()));
    send_req(mk_req(CMD_UNUSED, '1, '1, '1));
    send_req(mk_req(CMD_CLEAR, '1, '1, '1));
    send_req(mk_req(CMD_LOOKUP, '1, '1, '0));
  endtask

  task automatic test_full_and_resize();
    write_cap_log2(3'd0);
    for (int i = 0; i < 8; i++)
      send_req(mk_req(CMD_INSERT, 64'h100 + 64'(i), 64'(i) << 3, rand64()));
    send_req(mk_req(CMD_INSERT, 64'h1ff, 64'h0, rand64()));
    send_req(mk_req(CMD_LOOKUP, 64'h1fe, 64'h4, rand64()));
    send_req(mk_req(CMD_INSERT, 64'h105, 64'h28, 64'h5555_aaaa_5555_aaaa));
    send_req(mk_req(CMD_LOOKUP, 64'h107, 64'h38, rand64()));
    write_cap_log2(3'd7);
    send_req(mk_req(CMD_LOOKUP, 64'h103, 64'h18, rand64()));
    send_req(mk_req(CMD_LOOKUP, 64'h100, 64'h0, rand64()));
    send_req(mk_req(CMD_INSERT, 64'h2ff, 64'h5, rand64()));
    send_req(mk_req(CMD_CLEAR, '0, '0, '0));
  endtask

  function automatic req_t random_item(int pool_n);
    req_t r;
    int   c;
    int   idx;
    int   pick;
    c    = $urandom_range(99);
    idx  = $urandom_range(pool_n - 1);
    pick = $urandom_range(99);
    if (c < 1) r.cmd = CMD_CLEAR;
    else if (c < 4) r.cmd = CMD_UNUSED;
    else if (c < 54) r.cmd = CMD_INSERT;
    else r.cmd = CMD_LOOKUP;
    r.key      = pool_key[idx];
    r.key_hash = pool_hash[idx];
    if (pick < 8) begin
      r.key_hash = rand64();
    end else if (pick < 20) begin
      r.key      = rand64();
      r.key_hash = rand64();
    end
    r.value = rand64();
    return r;
  endfunction

  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input logic [2:0] c0, input logic [2:0] c1,
                                     input logic [2:0] c2, input int n_items);
    logic [2:0] caps [3];
    int         cap;
    int         pool_n;
    caps[0] = c0;
    caps[1] = c1;
    caps[2] = c2;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int s = 0; s < 3; s++) begin
      write_cap_log2(caps[s]);
      cap    = 1 << cap_log2_used();
      pool_n = cap + cap / 4 + 2;
      for (int i = 0; i < pool_n; i++) begin
        pool_key[i]  = rand64();
        pool_hash[i] = rand64();
        if (i % 2 == 1) pool_hash[i][5:0] = 6'($urandom_range(cap / 2 - 1));
      end
      send_req(mk_req(CMD_CLEAR, rand64(), rand64(), rand64()));
      for (int i = 0; i < n_items; i++) send_req(random_item(pool_n));
    end
  endtask

  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    req_item    = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    tx_idle_pct = 20;
    rx_idle_pct = 57;
    mismatch_count = 0;
    req_count   = 0;
    rsp_count   = 0;
    cfg_writes  = 0;
    for (int i = 0; i < 5; i++) status_seen[i] = 0;
    reset_table();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_full_and_resize();
    test_random_traffic(20, 57, 3'd3, 3'd4, 3'd2, 210);
    test_random_traffic(57, 20, 3'd5, 3'd1, 3'd6, 210);
    test_random_traffic(0, 0, 3'd6, 3'd3, 3'd5, 210);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d requests and %0d capacity writes, %0d responses checked",
             req_count, cfg_writes, rsp_count);
    $display("Status mix: %0d new, %0d updated, %0d found, %0d missed, %0d full",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lphash_pkg.sv
sv/lphash_ctrl.sv
sv/lphash_dp.sv
sv/linear_probe_hash_table_top.sv
dv/linear_probe_hash_table_top_tb.sv
